[src/fsps_pkg.sv]
// Shared constants for the fixed-step play session timer: field widths,
// command, status, mode and register index codes, register reset values.
// No dependencies.
package fsps_pkg;

    localparam int STEP_W     = 24;
    localparam int DELTA_W    = 32;
    localparam int MSTEPS_W   = 8;
    localparam int LEN_W      = 32;
    localparam int REV_W      = 64;
    localparam int CNT_W      = 64;
    localparam int DIGIT_W    = 8;
    localparam int NDIGITS    = CNT_W / DIGIT_W;
    localparam int IDX_W      = $clog2(NDIGITS);
    localparam int QUOT_W     = MSTEPS_W;
    localparam int STATUS_W   = 2;
    localparam int MODE_W     = 2;
    localparam int ACTION_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 208;

    localparam logic [ACTION_W-1:0] ACT_START   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PAUSE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RESUME  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_STEP    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_ADVANCE = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_STOP    = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CAPACITY = 2'd2;

    localparam logic [MODE_W-1:0] MODE_EDITING = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PLAYING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_DELTA   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SNAPSHOT_CAPACITY = 2'd3;

    localparam logic [STEP_W-1:0]   RST_STEP_LENGTH       = 24'd16667;
    localparam logic [DELTA_W-1:0]  RST_MAX_FRAME_DELTA   = 32'd250000;
    localparam logic [MSTEPS_W-1:0] RST_MAX_STEPS         = 8'd8;
    localparam logic [LEN_W-1:0]    RST_SNAPSHOT_CAPACITY = 32'd1048576;

endpackage

[src/fixed_step_play_session_timer_unit.sv]
// Fixed-step play session timer: command sequencer, step divider and
// digit-serial saturating counters in one module.
// Depends on fsps_pkg.

// One command is taken per beat on the s_ side and gives exactly one result
// beat on the m_ side. s_tready is high only while the unit waits for a
// command, so commands are handled one at a time; the result register lets
// the next command in while a result still waits for m_tready. After
// acceptance a command passes a decode state and the digit-serial update
// of the 64-bit tick, time and revision counters, 8 bits per cycle, and
// s_tready returns once its result is registered. An advance while playing
// gets its step count from a restoring divider, one quotient bit per cycle
// between a set-up and a finish state, ahead of the counter update. Configuration
// writes are always ready and take effect at once; write only while idle.
module fixed_step_play_session_timer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fsps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fsps_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // workspace[0], source_revision[64:1], snapshot_length[96:65],
    // frame_delta[128:97], zero fill
    input  logic [fsps_pkg::S_TDATA_W-1:0]      s_tdata,
    // action[2:0]
    input  logic [fsps_pkg::ACTION_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status[1:0], steps[9:2], mode[11:10], step_pending[12],
    // tick_total[76:13], simulated_time[140:77], change_count[204:141], zero fill
    output logic [fsps_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_CAP    = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;
    localparam logic [2:0] ST_SERIAL = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    localparam int DW  = fsps_pkg::DIGIT_W;
    localparam int CW  = fsps_pkg::CNT_W;
    localparam int AW  = fsps_pkg::DELTA_W;
    localparam int SW  = fsps_pkg::STEP_W;
    localparam int QW  = fsps_pkg::QUOT_W;
    localparam int XW  = fsps_pkg::IDX_W;
    localparam int FILL_W = fsps_pkg::M_TDATA_W - fsps_pkg::STATUS_W - QW
                            - fsps_pkg::MODE_W - 1 - 3 * CW;

    // control state
    logic [2:0]                       state_reg, state_next;
    logic [XW-1:0]                    cnt_reg, cnt_next;
    logic [fsps_pkg::MODE_W-1:0]      mode_reg, mode_next;
    logic                             pending_reg, pending_next;
    logic [AW-1:0]                    acc_reg, acc_next;
    logic [CW-1:0]                    tick_reg, tick_next;
    logic [CW-1:0]                    sim_reg, sim_next;
    logic [CW-1:0]                    rev_reg, rev_next;
    logic                             m_valid_reg, m_valid_next;

    // configuration
    logic [SW-1:0]                    step_reg, step_next;
    logic [AW-1:0]                    mfd_reg, mfd_next;
    logic [fsps_pkg::MSTEPS_W-1:0]    ms_reg, ms_next;
    logic [fsps_pkg::LEN_W-1:0]       capy_reg, capy_next;

    // payload and working registers
    logic [fsps_pkg::ACTION_W-1:0]    in_action_reg, in_action_next;
    logic                             in_rev_nz_reg, in_rev_nz_next;
    logic [fsps_pkg::LEN_W-1:0]       in_len_reg, in_len_next;
    logic [AW-1:0]                    in_delta_reg, in_delta_next;
    logic [AW:0]                      acc_sum_reg, acc_sum_next;
    logic [AW-1:0]                    cap_reg, cap_next;
    logic [AW-1:0]                    acc_cap_reg, acc_cap_next;
    logic [AW-1:0]                    rem_reg, rem_next;
    logic [AW-1:0]                    div_d_reg, div_d_next;
    logic [QW-1:0]                    q_reg, q_next;
    logic [QW-1:0]                    steps_reg, steps_next;
    logic [fsps_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic                             bump_reg, bump_next;
    logic [AW-1:0]                    sim_add_reg, sim_add_next;
    logic                             tick_c_reg, tick_c_next;
    logic                             sim_c_reg, sim_c_next;
    logic                             rev_c_reg, rev_c_next;
    logic [fsps_pkg::M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                             active;
    logic                             step_nz;
    logic                             first_digit;
    logic                             last_digit;
    logic                             last_qbit;
    logic [AW-1:0]                    bounded;
    logic [AW:0]                      acc_sum;
    logic [AW-1:0]                    cap_prod;
    logic                             div_ge;
    logic [AW-1:0]                    div_diff;
    logic [DW-1:0]                    t_add_digit;
    logic [DW:0]                      t_sum;
    logic [DW:0]                      s_sum;
    logic [DW:0]                      r_sum;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_tdata_reg;

    assign active      = (mode_reg == fsps_pkg::MODE_PLAYING) ||
                         (mode_reg == fsps_pkg::MODE_PAUSED);
    assign step_nz     = (step_reg != '0);
    assign first_digit = (cnt_reg == '0);
    assign last_digit  = (cnt_reg == XW'(fsps_pkg::NDIGITS - 1));
    assign last_qbit   = (cnt_reg == XW'(QW - 1));

    assign bounded  = (in_delta_reg < mfd_reg) ? in_delta_reg : mfd_reg;
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, bounded};
    // 24 x 8 bits: the product always fits in 32 bits
    assign cap_prod = {{(AW-SW){1'b0}}, step_reg}
                      * {{(AW-fsps_pkg::MSTEPS_W){1'b0}}, ms_reg};

    assign div_ge   = (rem_reg >= div_d_reg);
    assign div_diff = rem_reg - div_d_reg;

    // one 8-bit digit of each counter per cycle, least significant first
    assign t_add_digit = first_digit ? DW'(steps_reg) : '0;
    assign t_sum = {1'b0, tick_reg[DW-1:0]} + {1'b0, t_add_digit}
                   + {{DW{1'b0}}, tick_c_reg};
    assign s_sum = {1'b0, sim_reg[DW-1:0]} + {1'b0, sim_add_reg[DW-1:0]}
                   + {{DW{1'b0}}, sim_c_reg};
    assign r_sum = {1'b0, rev_reg[DW-1:0]} + {{DW{1'b0}}, bump_reg & first_digit}
                   + {{DW{1'b0}}, rev_c_reg};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mode_next      = mode_reg;
        pending_next   = pending_reg;
        acc_next       = acc_reg;
        tick_next      = tick_reg;
        sim_next       = sim_reg;
        rev_next       = rev_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        step_next      = step_reg;
        mfd_next       = mfd_reg;
        ms_next        = ms_reg;
        capy_next      = capy_reg;
        in_action_next = in_action_reg;
        in_rev_nz_next = in_rev_nz_reg;
        in_len_next    = in_len_reg;
        in_delta_next  = in_delta_reg;
        acc_sum_next   = acc_sum_reg;
        cap_next       = cap_reg;
        acc_cap_next   = acc_cap_reg;
        rem_next       = rem_reg;
        div_d_next     = div_d_reg;
        q_next         = q_reg;
        steps_next     = steps_reg;
        status_next    = status_reg;
        bump_next      = bump_reg;
        sim_add_next   = sim_add_reg;
        tick_c_next    = tick_c_reg;
        sim_c_next     = sim_c_reg;
        rev_c_next     = rev_c_reg;
        m_tdata_next   = m_tdata_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                fsps_pkg::CFG_STEP_LENGTH:       step_next = cfg_data[SW-1:0];
                fsps_pkg::CFG_MAX_FRAME_DELTA:   mfd_next  = cfg_data[AW-1:0];
                fsps_pkg::CFG_MAX_STEPS:         ms_next   = cfg_data[fsps_pkg::MSTEPS_W-1:0];
                fsps_pkg::CFG_SNAPSHOT_CAPACITY: capy_next = cfg_data[fsps_pkg::LEN_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    in_action_next = s_tuser;
                    in_rev_nz_next = |s_tdata[64:1];
                    in_len_next    = s_tdata[96:65];
                    in_delta_next  = s_tdata[128:97];
                    state_next     = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                status_next  = fsps_pkg::STATUS_OK;
                steps_next   = '0;
                bump_next    = 1'b0;
                sim_add_next = '0;
                cnt_next     = '0;
                tick_c_next  = 1'b0;
                sim_c_next   = 1'b0;
                rev_c_next   = 1'b0;
                state_next   = ST_SERIAL;
                case (in_action_reg)
                    fsps_pkg::ACT_START:
                    begin
                        if (active || !in_rev_nz_reg || in_len_reg == '0)
                            status_next = fsps_pkg::STATUS_INVALID;
                        else if (in_len_reg > capy_reg)
                            status_next = fsps_pkg::STATUS_CAPACITY;
                        else
                        begin
                            mode_next    = fsps_pkg::MODE_PLAYING;
                            tick_next    = '0;
                            sim_next     = '0;
                            acc_next     = '0;
                            pending_next = 1'b0;
                            bump_next    = 1'b1;
                        end
                    end
                    fsps_pkg::ACT_PAUSE:
                    begin
                        if (mode_reg != fsps_pkg::MODE_PLAYING)
                            status_next = fsps_pkg::STATUS_INVALID;
                        else
                        begin
                            mode_next    = fsps_pkg::MODE_PAUSED;
                            acc_next     = '0;
                            pending_next = 1'b0;
                            bump_next    = 1'b1;
                        end
                    end
                    fsps_pkg::ACT_RESUME:
                    begin
                        if (mode_reg != fsps_pkg::MODE_PAUSED)
                            status_next = fsps_pkg::STATUS_INVALID;
                        else
                        begin
                            mode_next    = fsps_pkg::MODE_PLAYING;
                            pending_next = 1'b0;
                            bump_next    = 1'b1;
                        end
                    end
                    fsps_pkg::ACT_STEP:
                    begin
                        if (mode_reg != fsps_pkg::MODE_PAUSED)
                            status_next = fsps_pkg::STATUS_INVALID;
                        else if (!pending_reg)
                        begin
                            pending_next = 1'b1;
                            bump_next    = 1'b1;
                        end
                    end
                    fsps_pkg::ACT_ADVANCE:
                    begin
                        if (!active)
                            status_next = fsps_pkg::STATUS_INVALID;
                        else if (mode_reg == fsps_pkg::MODE_PAUSED)
                        begin
                            // paused: a pending single step, delta ignored
                            if (pending_reg)
                            begin
                                steps_next   = QW'(1);
                                pending_next = 1'b0;
                                bump_next    = 1'b1;
                                sim_add_next = AW'(step_reg);
                            end
                        end
                        else
                        begin
                            acc_sum_next = acc_sum;
                            cap_next     = cap_prod;
                            state_next   = ST_CAP;
                        end
                    end
                    fsps_pkg::ACT_STOP:
                    begin
                        if (active)
                        begin
                            mode_next    = fsps_pkg::MODE_EDITING;
                            tick_next    = '0;
                            sim_next     = '0;
                            acc_next     = '0;
                            pending_next = 1'b0;
                            bump_next    = 1'b1;
                        end
                    end
                    default:
                        status_next = fsps_pkg::STATUS_INVALID;
                endcase
            end

            ST_CAP:
            begin
                if (acc_sum_reg > {1'b0, cap_reg})
                    acc_cap_next = cap_reg;
                else
                    acc_cap_next = acc_sum_reg[AW-1:0];
                rem_next   = (acc_sum_reg > {1'b0, cap_reg}) ? cap_reg : acc_sum_reg[AW-1:0];
                div_d_next = AW'({step_reg, {(QW-1){1'b0}}});
                q_next     = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                // accumulator never exceeds max_steps * step, so 8 bits suffice
                if (div_ge && step_nz)
                begin
                    rem_next = div_diff;
                    q_next   = {q_reg[QW-2:0], 1'b1};
                end
                else
                    q_next   = {q_reg[QW-2:0], 1'b0};
                div_d_next = div_d_reg >> 1;
                cnt_next   = cnt_reg + XW'(1);
                if (last_qbit)
                    state_next = ST_FIN;
            end

            ST_FIN:
            begin
                steps_next   = q_reg;
                acc_next     = rem_reg;
                sim_add_next = acc_cap_reg - rem_reg;
                bump_next    = (q_reg != '0);
                cnt_next     = '0;
                tick_c_next  = 1'b0;
                sim_c_next   = 1'b0;
                rev_c_next   = 1'b0;
                state_next   = ST_SERIAL;
            end

            ST_SERIAL:
            begin
                tick_c_next  = t_sum[DW];
                sim_c_next   = s_sum[DW];
                rev_c_next   = r_sum[DW];
                sim_add_next = sim_add_reg >> DW;
                // carry out of the top digit: saturate
                tick_next = (last_digit && t_sum[DW]) ? '1 : {t_sum[DW-1:0], tick_reg[CW-1:DW]};
                sim_next  = (last_digit && s_sum[DW]) ? '1 : {s_sum[DW-1:0], sim_reg[CW-1:DW]};
                rev_next  = (last_digit && r_sum[DW]) ? '1 : {r_sum[DW-1:0], rev_reg[CW-1:DW]};
                cnt_next  = cnt_reg + XW'(1);
                if (last_digit)
                    state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_tdata_next = {{FILL_W{1'b0}}, rev_reg, sim_reg, tick_reg, pending_reg,
                                    mode_reg, steps_reg, status_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            mode_reg    <= fsps_pkg::MODE_EDITING;
            pending_reg <= 1'b0;
            acc_reg     <= '0;
            tick_reg    <= '0;
            sim_reg     <= '0;
            rev_reg     <= '0;
            m_valid_reg <= 1'b0;
            step_reg    <= fsps_pkg::RST_STEP_LENGTH;
            mfd_reg     <= fsps_pkg::RST_MAX_FRAME_DELTA;
            ms_reg      <= fsps_pkg::RST_MAX_STEPS;
            capy_reg    <= fsps_pkg::RST_SNAPSHOT_CAPACITY;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            mode_reg    <= mode_next;
            pending_reg <= pending_next;
            acc_reg     <= acc_next;
            tick_reg    <= tick_next;
            sim_reg     <= sim_next;
            rev_reg     <= rev_next;
            m_valid_reg <= m_valid_next;
            step_reg    <= step_next;
            mfd_reg     <= mfd_next;
            ms_reg      <= ms_next;
            capy_reg    <= capy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_action_reg <= in_action_next;
        in_rev_nz_reg <= in_rev_nz_next;
        in_len_reg    <= in_len_next;
        in_delta_reg  <= in_delta_next;
        acc_sum_reg   <= acc_sum_next;
        cap_reg       <= cap_next;
        acc_cap_reg   <= acc_cap_next;
        rem_reg       <= rem_next;
        div_d_reg     <= div_d_next;
        q_reg         <= q_next;
        steps_reg     <= steps_next;
        status_reg    <= status_next;
        bump_reg      <= bump_next;
        sim_add_reg   <= sim_add_next;
        tick_c_reg    <= tick_c_next;
        sim_c_reg     <= sim_c_next;
        rev_c_reg     <= rev_c_next;
        m_tdata_reg   <= m_tdata_next;
    end

    a_one_cmd_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while one is in progress");

    a_pending_only_paused: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> mode_reg == fsps_pkg::MODE_PAUSED)
        else $error("step pending outside paused mode");

    a_acc_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != fsps_pkg::MODE_PLAYING |-> acc_reg == '0)
        else $error("accumulator holds time while not playing");

    a_quot_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |-> q_reg <= ms_reg)
        else $error("step count above max_steps");

    a_error_no_steps: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (status_reg == fsps_pkg::STATUS_OK || steps_reg == '0))
        else $error("failed command granted steps");

endmodule

[verif/fsps_checker.sv]
// Scoreboard for the fixed-step play session timer. It watches the config, command and
// result channels, keeps its own copy of the session state and checks every result beat.
// Depends on fsps_pkg.
`timescale 1ns / 100ps

module fsps_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [fsps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fsps_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [fsps_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [fsps_pkg::ACTION_W-1:0]       s_tuser,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [fsps_pkg::M_TDATA_W-1:0]      m_tdata,
    output int                                  mismatch_count,
    output int                                  reports_due
);

    localparam int PRINT_CAP = 40;

    // first member sits in the top bits, so this lines up with m_tdata[204:0]
    typedef struct packed {
        logic [fsps_pkg::CNT_W-1:0]    changes;
        logic [fsps_pkg::CNT_W-1:0]    sim_us;
        logic [fsps_pkg::CNT_W-1:0]    ticks;
        logic                          step_req;
        logic [fsps_pkg::MODE_W-1:0]   mode;
        logic [fsps_pkg::QUOT_W-1:0]   steps;
        logic [fsps_pkg::STATUS_W-1:0] status;
    } session_report_t;

    session_report_t pending_reports[$];

    // register copies
    logic [fsps_pkg::STEP_W-1:0]   step_len;
    logic [fsps_pkg::DELTA_W-1:0]  frame_cap;
    logic [fsps_pkg::MSTEPS_W-1:0] step_cap;
    logic [fsps_pkg::LEN_W-1:0]    snap_cap;

    // session state
    logic [fsps_pkg::MODE_W-1:0]   mode_now;
    logic                          ws_now;
    logic [fsps_pkg::REV_W-1:0]    rev_now;
    logic [fsps_pkg::CNT_W-1:0]    tick_now;
    logic [fsps_pkg::CNT_W-1:0]    simt_now;
    logic [31:0]                   accum;
    logic                          step_req;
    logic [fsps_pkg::CNT_W-1:0]    change_now;

    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[64] ? {64{1'b1}} : total[63:0];
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("%0t: mismatch: %s", $time, msg);
        mismatch_count = mismatch_count + 1;
    endtask

    task automatic check_field(input string label, input logic [63:0] seen,
                               input logic [63:0] wanted);
        if (seen !== wanted)
            flag_mismatch($sformatf("%s got 0x%0h want 0x%0h", label, seen, wanted));
    endtask

    // one command against the session state; returns the result it should produce
    task automatic apply_session_command(input logic [fsps_pkg::ACTION_W-1:0] act,
                                         input logic ws,
                                         input logic [fsps_pkg::REV_W-1:0] rev,
                                         input logic [fsps_pkg::LEN_W-1:0] len,
                                         input logic [fsps_pkg::DELTA_W-1:0] delta,
                                         output session_report_t rep);
        logic [fsps_pkg::STATUS_W-1:0] st;
        logic [fsps_pkg::QUOT_W-1:0]   granted;
        logic [63:0]                   bounded;
        logic [63:0]                   ceiling;
        logic [63:0]                   acc;
        logic [63:0]                   quot;
        st      = fsps_pkg::STATUS_OK;
        granted = '0;
        case (act)
            fsps_pkg::ACT_START:
                if (mode_now != fsps_pkg::MODE_EDITING || rev == '0 || len == '0)
                    st = fsps_pkg::STATUS_INVALID;
                else if (len > snap_cap)
                    st = fsps_pkg::STATUS_CAPACITY;
                else
                begin
                    ws_now     = ws;
                    mode_now   = fsps_pkg::MODE_PLAYING;
                    rev_now    = rev;
                    tick_now   = '0;
                    simt_now   = '0;
                    accum      = '0;
                    step_req   = 1'b0;
                    change_now = sat_sum(change_now, 64'd1);
                end
            fsps_pkg::ACT_PAUSE:
                if (mode_now != fsps_pkg::MODE_PLAYING)
                    st = fsps_pkg::STATUS_INVALID;
                else
                begin
                    mode_now   = fsps_pkg::MODE_PAUSED;
                    accum      = '0;
                    step_req   = 1'b0;
                    change_now = sat_sum(change_now, 64'd1);
                end
            fsps_pkg::ACT_RESUME:
                if (mode_now != fsps_pkg::MODE_PAUSED)
                    st = fsps_pkg::STATUS_INVALID;
                else
                begin
                    mode_now   = fsps_pkg::MODE_PLAYING;
                    step_req   = 1'b0;
                    change_now = sat_sum(change_now, 64'd1);
                end
            fsps_pkg::ACT_STEP:
                if (mode_now != fsps_pkg::MODE_PAUSED)
                    st = fsps_pkg::STATUS_INVALID;
                else if (!step_req)
                begin
                    step_req   = 1'b1;
                    change_now = sat_sum(change_now, 64'd1);
                end
            fsps_pkg::ACT_ADVANCE:
                if (mode_now == fsps_pkg::MODE_EDITING)
                    st = fsps_pkg::STATUS_INVALID;
                else
                begin
                    if (mode_now == fsps_pkg::MODE_PAUSED)
                    begin
                        // delta is ignored while paused
                        if (step_req)
                        begin
                            granted  = 8'd1;
                            step_req = 1'b0;
                        end
                    end
                    else
                    begin
                        bounded = (delta < frame_cap) ? 64'(delta) : 64'(frame_cap);
                        ceiling = 64'(step_len) * 64'(step_cap);
                        acc     = 64'(accum) + bounded;
                        if (acc > ceiling)
                            acc = ceiling;
                        if (step_len != '0)
                        begin
                            quot = acc / 64'(step_len);
                            if (quot > 64'(step_cap))
                                quot = 64'(step_cap);
                            granted = quot[fsps_pkg::QUOT_W-1:0];
                            acc     = acc - quot * 64'(step_len);
                        end
                        else
                            acc = '0;
                        accum = acc[31:0];
                    end
                    if (granted != '0)
                    begin
                        tick_now   = sat_sum(tick_now, 64'(granted));
                        simt_now   = sat_sum(simt_now, 64'(granted) * 64'(step_len));
                        change_now = sat_sum(change_now, 64'd1);
                    end
                end
            fsps_pkg::ACT_STOP:
                if (mode_now != fsps_pkg::MODE_EDITING)
                begin
                    mode_now   = fsps_pkg::MODE_EDITING;
                    rev_now    = '0;
                    tick_now   = '0;
                    simt_now   = '0;
                    accum      = '0;
                    step_req   = 1'b0;
                    change_now = sat_sum(change_now, 64'd1);
                end
            default:
                st = fsps_pkg::STATUS_INVALID;
        endcase
        rep.status   = st;
        rep.steps    = granted;
        rep.mode     = mode_now;
        rep.step_req = step_req;
        rep.ticks    = tick_now;
        rep.sim_us   = simt_now;
        rep.changes  = change_now;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        session_report_t want;
        session_report_t seen;
        if (!rst_n)
        begin
            step_len       = fsps_pkg::RST_STEP_LENGTH;
            frame_cap      = fsps_pkg::RST_MAX_FRAME_DELTA;
            step_cap       = fsps_pkg::RST_MAX_STEPS;
            snap_cap       = fsps_pkg::RST_SNAPSHOT_CAPACITY;
            mode_now       = fsps_pkg::MODE_EDITING;
            ws_now         = 1'b0;
            rev_now        = '0;
            tick_now       = '0;
            simt_now       = '0;
            accum          = '0;
            step_req       = 1'b0;
            change_now     = '0;
            mismatch_count = 0;
            pending_reports.delete();
            reports_due    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    fsps_pkg::CFG_STEP_LENGTH:
                        step_len  = cfg_data[fsps_pkg::STEP_W-1:0];
                    fsps_pkg::CFG_MAX_FRAME_DELTA:
                        frame_cap = cfg_data[fsps_pkg::DELTA_W-1:0];
                    fsps_pkg::CFG_MAX_STEPS:
                        step_cap  = cfg_data[fsps_pkg::MSTEPS_W-1:0];
                    fsps_pkg::CFG_SNAPSHOT_CAPACITY:
                        snap_cap  = cfg_data[fsps_pkg::LEN_W-1:0];
                    default: ;
                endcase
            if (s_tvalid && s_tready)
            begin
                apply_session_command(s_tuser, s_tdata[0], s_tdata[64:1], s_tdata[96:65],
                                      s_tdata[128:97], want);
                pending_reports.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                seen = m_tdata[$bits(session_report_t)-1:0];
                if (pending_reports.size() == 0)
                    flag_mismatch($sformatf("result beat with no command outstanding: 0x%0h",
                                            seen));
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("status", 64'(seen.status), 64'(want.status));
                    check_field("steps", 64'(seen.steps), 64'(want.steps));
                    check_field("mode", 64'(seen.mode), 64'(want.mode));
                    check_field("step_pending", 64'(seen.step_req), 64'(want.step_req));
                    check_field("tick_total", seen.ticks, want.ticks);
                    check_field("simulated_time", seen.sim_us, want.sim_us);
                    check_field("change_count", seen.changes, want.changes);
                end
            end
            reports_due = pending_reports.size();
        end
    end

endmodule

[verif/testbench.sv]
// Top of the play session timer bench: clock, reset, command and config stimulus with
// bursty sending and a stalling receiver, plus the final verdict.
// Depends on fsps_pkg, fsps_checker and fixed_step_play_session_timer_unit.
`timescale 1ns / 100ps

module testbench;

    localparam logic [fsps_pkg::ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [fsps_pkg::ACTION_W-1:0] ACT_SPARE_B = 3'd7;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int TAIL_CYCLES   = 40;
    localparam int RANDOM_ROUND  = 150;
    localparam int ZERO_ROUND    = 40;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [fsps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fsps_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [fsps_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic [fsps_pkg::ACTION_W-1:0]   s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [fsps_pkg::M_TDATA_W-1:0]  m_tdata;

    int          mismatch_count;
    int          reports_due;
    int          cycle_count = 0;
    int          burst_left  = 0;
    int          stall_span  = 0;
    int          stall_style = 0;
    logic [31:0] cur_step    = 32'(fsps_pkg::RST_STEP_LENGTH);
    logic [31:0] cur_cap     = 32'(fsps_pkg::RST_SNAPSHOT_CAPACITY);

    fixed_step_play_session_timer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    fsps_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .reports_due    (reports_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("fixed_step_play_session_timer_unit verification failed");
            $finish;
        end
    end

    // receiver: picks one of four stall styles at random and holds it for a random span
    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_span  = $urandom_range(20, 200);
        end
        else
            stall_span = stall_span - 1;
        case (stall_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 5) == 0);
            default: m_tready <= ((stall_span % 7) < 3);
        endcase
    end

    // entered and left at a falling edge; s_tvalid stays high for a following beat
    task automatic issue_command(input logic [fsps_pkg::ACTION_W-1:0] act, input logic ws,
                                 input logic [63:0] rev, input logic [31:0] len,
                                 input logic [31:0] delta);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'd0, delta, len, rev, ws};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left = burst_left - 1;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [fsps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold off the sender until every result is back, then let the unit finish up
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (reports_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_timer(input logic [31:0] step, input logic [31:0] delta_cap,
                                 input logic [31:0] most, input logic [31:0] cap);
        drain_results();
        write_reg(fsps_pkg::CFG_STEP_LENGTH, step);
        write_reg(fsps_pkg::CFG_MAX_FRAME_DELTA, delta_cap);
        write_reg(fsps_pkg::CFG_MAX_STEPS, most);
        write_reg(fsps_pkg::CFG_SNAPSHOT_CAPACITY, cap);
        cfg_valid <= 1'b0;
        cur_step = step & 32'h00FF_FFFF;
        cur_cap  = cap;
    endtask

    // mostly sessions that get going: advances dominate, with pause / step traffic and
    // the odd broken start or spare code mixed in
    task automatic random_round(input int count);
        int                            roll;
        logic [fsps_pkg::ACTION_W-1:0] act;
        logic [63:0]                   rev;
        logic [31:0]                   len;
        logic [31:0]                   delta;
        logic [63:0]                   span;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                drain_results();
            roll = $urandom_range(0, 99);
            if (roll < 40)
                act = fsps_pkg::ACT_ADVANCE;
            else if (roll < 52)
                act = fsps_pkg::ACT_START;
            else if (roll < 62)
                act = fsps_pkg::ACT_PAUSE;
            else if (roll < 74)
                act = fsps_pkg::ACT_STEP;
            else if (roll < 84)
                act = fsps_pkg::ACT_RESUME;
            else if (roll < 92)
                act = fsps_pkg::ACT_STOP;
            else if (roll < 95)
                act = ($urandom_range(0, 1) == 0) ? ACT_SPARE_A : ACT_SPARE_B;
            else
                act = 3'($urandom_range(0, 7));

            rev = ($urandom_range(0, 9) == 0) ? 64'd0 : {$urandom, $urandom};

            roll = $urandom_range(0, 99);
            if (roll < 5)
                len = '0;
            else if (roll < 15)
                len = cur_cap;
            else if (roll < 25)
                len = cur_cap + 32'd1;
            else if (roll < 35)
                len = '1;
            else
                len = $urandom_range(1, cur_cap);

            roll = $urandom_range(0, 99);
            if (roll < 60)
            begin
                span = 64'(cur_step) * 3;
                if (span > 64'h0000_0000_FFFF_FFFF)
                    span = 64'h0000_0000_FFFF_FFFF;
                delta = $urandom_range(0, span[31:0]);
            end
            else if (roll < 68)
                delta = '0;
            else if (roll < 75)
                delta = '1;
            else
                delta = $urandom;

            issue_command(act, 1'($urandom_range(0, 1)), rev, len, delta);
        end
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // mode rules from editing, start checks, clamp and pause stepping at reset config
        issue_command(fsps_pkg::ACT_ADVANCE, 1'b0, 64'd1, 32'd1, '1);
        issue_command(fsps_pkg::ACT_PAUSE,   1'b0, 64'd1, 32'd1, 32'd0);
        issue_command(fsps_pkg::ACT_STOP,    1'b0, 64'd1, 32'd1, 32'd0);
        issue_command(ACT_SPARE_A,           1'b1, '1, '1, '1);
        issue_command(ACT_SPARE_B,           1'b0, 64'd1, 32'd1, 32'd0);
        issue_command(fsps_pkg::ACT_START,   1'b1, 64'd0, 32'd5, 32'd0);
        issue_command(fsps_pkg::ACT_START,   1'b1, 64'd1, 32'd0, 32'd0);
        issue_command(fsps_pkg::ACT_START,   1'b1, 64'd0,
                      32'(fsps_pkg::RST_SNAPSHOT_CAPACITY) + 32'd1, 32'd0);
        issue_command(fsps_pkg::ACT_START,   1'b1, '1, '1, 32'd0);
        issue_command(fsps_pkg::ACT_START,   1'b1, '1,
                      32'(fsps_pkg::RST_SNAPSHOT_CAPACITY), 32'd0);
        issue_command(fsps_pkg::ACT_START,   1'b0, 64'd5, 32'd1, 32'd0);
        issue_command(fsps_pkg::ACT_RESUME,  1'b0, 64'd1, 32'd1, 32'd0);
        issue_command(fsps_pkg::ACT_STEP,    1'b0, 64'd1, 32'd1, 32'd0);
        issue_command(fsps_pkg::ACT_ADVANCE, 1'b0, 64'd1, 32'd1, 32'd0);
        issue_command(fsps_pkg::ACT_ADVANCE, 1'b0, 64'd1, 32'd1,
                      32'(fsps_pkg::RST_STEP_LENGTH) - 32'd1);
        issue_command(fsps_pkg::ACT_ADVANCE, 1'b0, 64'd1, 32'd1, '1);
        issue_command(fsps_pkg::ACT_PAUSE,   1'b0, 64'd1, 32'd1, 32'd0);
        issue_command(fsps_pkg::ACT_PAUSE,   1'b0, 64'd1, 32'd1, 32'd0);
        issue_command(fsps_pkg::ACT_ADVANCE, 1'b0, 64'd1, 32'd1, '1);
        issue_command(fsps_pkg::ACT_STEP,    1'b0, 64'd1, 32'd1, 32'd0);
        issue_command(fsps_pkg::ACT_STEP,    1'b0, 64'd1, 32'd1, 32'd0);
        issue_command(fsps_pkg::ACT_ADVANCE, 1'b0, 64'd1, 32'd1, 32'd0);
        issue_command(fsps_pkg::ACT_STEP,    1'b0, 64'd1, 32'd1, 32'd0);
        issue_command(fsps_pkg::ACT_RESUME,  1'b0, 64'd1, 32'd1, 32'd0);
        issue_command(fsps_pkg::ACT_STOP,    1'b1, 64'd1, 32'd1, 32'd0);
        issue_command(fsps_pkg::ACT_START,   1'b0, 64'd1, 32'd1, 32'd0);
        issue_command(fsps_pkg::ACT_PAUSE,   1'b0, 64'd1, 32'd1, 32'd0);
        issue_command(fsps_pkg::ACT_STOP,    1'b0, 64'd1, 32'd1, 32'd0);

        random_round(RANDOM_ROUND);

        // extremes: shortest step with the widest limits, then longest step, then one step per advance
        program_timer(32'd1, '1, 32'd255, '1);
        random_round(RANDOM_ROUND);
        program_timer(32'h00FF_FFFF, '1, 32'd255, 32'd1);
        random_round(RANDOM_ROUND);
        program_timer(32'd1000, 32'd1000, 32'd1, 32'd4096);
        random_round(RANDOM_ROUND);

        // zero step length, then zero step limit: accumulator pinned at zero
        program_timer(32'd0, 32'd1000, 32'd8, 32'd4096);
        random_round(ZERO_ROUND);
        program_timer(32'd500, 32'd4000, 32'd0, 32'd4096);
        random_round(ZERO_ROUND);

        program_timer(32'($urandom_range(1000, 100000)), 32'd0, 32'd0, 32'd0);
        program_timer(cur_step, 32'($urandom_range(cur_step, cur_step * 20)),
                      32'($urandom_range(1, 16)), 32'($urandom_range(1, 2000000)));
        random_round(RANDOM_ROUND);

        s_tvalid <= 1'b0;
        while (reports_due != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("fixed_step_play_session_timer_unit verification clean");
        else
            $display("fixed_step_play_session_timer_unit verification failed");
        $finish;
    end

endmodule
